>>> rtl/dipm_pkg.sv
package dipm_pkg;

    // input sample width and derived datapath widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int BIAS_W       = SAMPLE_WIDTH + 1;
    localparam int DELTA_W      = SAMPLE_WIDTH + 2;
    localparam int GAIN_W       = 16;
    localparam int PROD_P_W     = DELTA_W + GAIN_W + 1;
    localparam int PROD_I_W     = BIAS_W + GAIN_W + 1;
    localparam int FRAC_W       = 8;
    localparam int SUM_W        = PROD_P_W + 2;
    localparam int QUO_W        = SUM_W - FRAC_W;
    localparam int ACC_W        = 15;
    localparam int SCALE_W      = 14;
    localparam int DRIVE_W      = 15;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_POS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_NEG    = 3'd5;

    // reset values of the registers
    localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 16'd2560;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 16'd2560;
    localparam logic [SCALE_W-1:0] RST_FULL_SCALE  = 14'd8400;
    localparam logic [SCALE_W-1:0] RST_DRIVE_LIMIT = 14'd8200;
    localparam logic [SCALE_W-1:0] RST_DEAD_POS    = 14'd1423;
    localparam logic [SCALE_W-1:0] RST_DEAD_NEG    = 14'd1330;

    // left sign flip thresholds
    localparam int FLIP_TARGET_MAX = 3;
    localparam int FLIP_ACC_MIN    = 1000;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [SCALE_W-1:0] full_scale;
        logic [SCALE_W-1:0] drive_limit;
        logic [SCALE_W-1:0] dead_pos;
        logic [SCALE_W-1:0] dead_neg;
    } cfg_t;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
    } lane_ctrl_t;

endpackage

>>> rtl/dual_incremental_pi_motor_drive.sv
// Two-motor incremental PI drive with PWM compare mapping.
// Input channel (s_valid/s_ready): one word per control tick carrying the
// encoder counts and speed targets of the left and right motors.
// Result channel (m_valid/m_ready): one word per input word with the limited
// drives and the A/B compare values of both motors, in input order.
// Config channel (cfg_valid/cfg_ready): index and data of one register
// (gains, full scale, drive limit, dead-zone edges); always ready, and to be
// written only while no word is in flight.
// Path: an accepted word passes the stage 1 registers, the accumulator
// register and the output word register before its result is valid.
// Throughput: one word per cycle while the output is not stalled; the left
// and right lanes run side by side, and each lane's accumulator loop (add,
// truncate toward zero, clamp) closes through its accumulator register.
// Stalls: each of the three stages holds its word while the next is full and
// cannot advance, so bubbles are squeezed out and s_ready drops only when all
// stages are full and m_ready is low.
// Reset: accumulators and previous biases clear to zero, registers return to
// their defaults, and the pipeline empties.
module dual_incremental_pi_motor_drive import dipm_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_encoder_left,
    input  logic signed [SAMPLE_WIDTH-1:0] s_encoder_right,
    input  logic signed [SAMPLE_WIDTH-1:0] s_target_left,
    input  logic signed [SAMPLE_WIDTH-1:0] s_target_right,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DRIVE_W-1:0]      m_drive_left,
    output logic signed [DRIVE_W-1:0]      m_drive_right,
    output logic [SCALE_W-1:0]             m_left_ch_a,
    output logic [SCALE_W-1:0]             m_left_ch_b,
    output logic [SCALE_W-1:0]             m_right_ch_a,
    output logic [SCALE_W-1:0]             m_right_ch_b,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    cfg_t       cfg_reg;
    lane_ctrl_t lane_ctrl;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    logic       load_s3;
    logic signed [ACC_W-1:0] acc_left;
    logic signed [ACC_W-1:0] acc_right;

    // register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= RST_GAIN_P;
            cfg_reg.gain_i      <= RST_GAIN_I;
            cfg_reg.full_scale  <= RST_FULL_SCALE;
            cfg_reg.drive_limit <= RST_DRIVE_LIMIT;
            cfg_reg.dead_pos    <= RST_DEAD_POS;
            cfg_reg.dead_neg    <= RST_DEAD_NEG;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data;
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data;
                REG_FULL_SCALE:  cfg_reg.full_scale  <= cfg_data[SCALE_W-1:0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit <= cfg_data[SCALE_W-1:0];
                REG_DEAD_POS:    cfg_reg.dead_pos    <= cfg_data[SCALE_W-1:0];
                REG_DEAD_NEG:    cfg_reg.dead_neg    <= cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake, each stage advances when the next has room
    assign rdy3    = ~v3_reg | m_ready;
    assign rdy2    = ~v2_reg | rdy3;
    assign rdy1    = ~v1_reg | rdy2;
    assign s_ready = rdy1;
    assign m_valid = v3_reg;

    assign lane_ctrl.load_s1 = s_valid & rdy1;
    assign lane_ctrl.load_s2 = v1_reg & rdy2;
    assign load_s3           = v2_reg & rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // left lane with sign flip and dead zone
    dipm_lane u_lane_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .cfg      (cfg_reg),
        .shape_en (1'b1),
        .encoder  (s_encoder_left),
        .target   (s_target_left),
        .acc      (acc_left)
    );

    // right lane, plain PI
    dipm_lane u_lane_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (lane_ctrl),
        .cfg      (cfg_reg),
        .shape_en (1'b0),
        .encoder  (s_encoder_right),
        .target   (s_target_right),
        .acc      (acc_right)
    );

    // limit and compare mapping of both lanes
    dipm_merge u_merge (
        .aclk        (aclk),
        .load        (load_s3),
        .cfg         (cfg_reg),
        .acc_left    (acc_left),
        .acc_right   (acc_right),
        .drive_left  (m_drive_left),
        .drive_right (m_drive_right),
        .left_ch_a   (m_left_ch_a),
        .left_ch_b   (m_left_ch_b),
        .right_ch_a  (m_right_ch_a),
        .right_ch_b  (m_right_ch_b)
    );

    // input stalls only when every stage is full and the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && m_valid && !m_ready))
        else $error("input stalled with room in the pipeline");

    // a word reaches stage 2 only from stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("stage 2 filled without a stage 1 word");

    // a word reaches the output only from stage 2
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg))
        else $error("output filled without a stage 2 word");

    // delivered drives respect the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_drive_left <= $signed({1'b0, cfg_reg.drive_limit}))
                  && (m_drive_left >= -$signed({1'b0, cfg_reg.drive_limit}))
                  && (m_drive_right <= $signed({1'b0, cfg_reg.drive_limit}))
                  && (m_drive_right >= -$signed({1'b0, cfg_reg.drive_limit}))))
        else $error("drive outside limit");

    // a zero left drive turns both left channels off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_left == '0)) |-> ((m_left_ch_a == '0) && (m_left_ch_b == '0)))
        else $error("left channels active at zero drive");

endmodule

>>> rtl/dipm_lane.sv
module dipm_lane import dipm_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lane_ctrl_t                     ctrl,
    input  cfg_t                           cfg,
    input  logic                           shape_en,
    input  logic signed [SAMPLE_WIDTH-1:0] encoder,
    input  logic signed [SAMPLE_WIDTH-1:0] target,
    output logic signed [ACC_W-1:0]        acc
);

    localparam logic signed [SAMPLE_WIDTH-1:0] TGT_HI = SAMPLE_WIDTH'(FLIP_TARGET_MAX);
    localparam logic signed [SAMPLE_WIDTH-1:0] TGT_LO = -TGT_HI;
    localparam logic signed [ACC_W-1:0]        ACC_HI = ACC_W'(FLIP_ACC_MIN);
    localparam logic signed [ACC_W-1:0]        ACC_LO = -ACC_HI;

    logic signed [BIAS_W-1:0]   bias;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [GAIN_W:0]     gain_p_s;
    logic signed [GAIN_W:0]     gain_i_s;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic                       tgt_pos;
    logic                       tgt_neg;
    logic                       tgt_small;

    logic signed [BIAS_W-1:0]   prev_bias_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic                       tgt_pos_reg;
    logic                       tgt_neg_reg;
    logic                       tgt_small_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;

    logic                       flip;
    logic signed [ACC_W-1:0]    acc_f;
    logic signed [SUM_W-1:0]    sum;
    logic signed [QUO_W-1:0]    quo;
    logic signed [QUO_W-1:0]    fs_q;
    logic signed [ACC_W-1:0]    clamped;
    logic signed [ACC_W-1:0]    dp_s;
    logic signed [ACC_W-1:0]    dn_s;

    // stage 1: bias, change in bias and the two gain products
    assign bias     = BIAS_W'(encoder) - BIAS_W'(target);
    assign delta    = DELTA_W'(bias) - DELTA_W'(prev_bias_reg);
    assign gain_p_s = $signed({1'b0, cfg.gain_p});
    assign gain_i_s = $signed({1'b0, cfg.gain_i});
    assign prod_p   = PROD_P_W'(delta) * PROD_P_W'(gain_p_s);
    assign prod_i   = PROD_I_W'(bias) * PROD_I_W'(gain_i_s);

    // target classification for the left shaping
    assign tgt_neg   = target[SAMPLE_WIDTH-1];
    assign tgt_pos   = ~target[SAMPLE_WIDTH-1] & (|target);
    assign tgt_small = (target <= TGT_HI) && (target >= TGT_LO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_bias_reg <= '0;
        end else if (ctrl.load_s1) begin
            prev_bias_reg <= bias;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_s1) begin
            prod_p_reg    <= prod_p;
            prod_i_reg    <= prod_i;
            tgt_pos_reg   <= tgt_pos;
            tgt_neg_reg   <= tgt_neg;
            tgt_small_reg <= tgt_small;
        end
    end

    // stage 2: sign flip, accumulate, truncate toward zero, clamp
    assign flip  = shape_en & tgt_small_reg &
                   ((tgt_pos_reg & (acc_reg > ACC_HI)) | (tgt_neg_reg & (acc_reg < ACC_LO)));
    assign acc_f = flip ? -acc_reg : acc_reg;
    assign sum   = (SUM_W'(acc_f) <<< FRAC_W) + SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg);
    assign fs_q  = $signed(QUO_W'({1'b0, cfg.full_scale}));
    assign dp_s  = $signed({1'b0, cfg.dead_pos});
    assign dn_s  = $signed({1'b0, cfg.dead_neg});

    always_comb begin
        quo = sum[SUM_W-1:FRAC_W];
        if (sum[SUM_W-1] && (|sum[FRAC_W-1:0])) begin
            quo = quo + QUO_W'(1);
        end
    end

    always_comb begin
        priority if (quo > fs_q) begin
            clamped = ACC_W'(fs_q);
        end else if (quo < -fs_q) begin
            clamped = ACC_W'(-fs_q);
        end else begin
            clamped = ACC_W'(quo);
        end
    end

    // left dead-zone jump
    always_comb begin
        acc_next = clamped;
        if (shape_en && (clamped < dp_s) && (clamped > -dn_s)) begin
            priority if (tgt_pos_reg) begin
                acc_next = -dn_s;
            end else if (tgt_neg_reg) begin
                acc_next = dp_s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.load_s2) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/dipm_merge.sv
module dipm_merge import dipm_pkg::*; (
    input  logic                      aclk,
    input  logic                      load,
    input  cfg_t                      cfg,
    input  logic signed [ACC_W-1:0]   acc_left,
    input  logic signed [ACC_W-1:0]   acc_right,
    output logic signed [DRIVE_W-1:0] drive_left,
    output logic signed [DRIVE_W-1:0] drive_right,
    output logic [SCALE_W-1:0]        left_ch_a,
    output logic [SCALE_W-1:0]        left_ch_b,
    output logic [SCALE_W-1:0]        right_ch_a,
    output logic [SCALE_W-1:0]        right_ch_b
);

    // symmetric limit
    function automatic logic signed [DRIVE_W-1:0] limit_drive(
        input logic signed [ACC_W-1:0] a,
        input logic [SCALE_W-1:0]      lim
    );
        logic signed [DRIVE_W-1:0] lim_s;
        lim_s = $signed({1'b0, lim});
        priority if (DRIVE_W'(a) > lim_s) begin
            return lim_s;
        end else if (DRIVE_W'(a) < -lim_s) begin
            return -lim_s;
        end else begin
            return DRIVE_W'(a);
        end
    endfunction

    // complementary compare pair, floored at zero
    function automatic logic [2*SCALE_W-1:0] map_pair(
        input logic signed [DRIVE_W-1:0] d,
        input logic [SCALE_W-1:0]        fs
    );
        logic signed [DRIVE_W:0] fs_s;
        logic signed [DRIVE_W:0] t;
        logic [SCALE_W-1:0]      a;
        logic [SCALE_W-1:0]      b;
        fs_s = $signed({2'b00, fs});
        t    = '0;
        a    = '0;
        b    = '0;
        priority if (d > 0) begin
            t = fs_s - (DRIVE_W+1)'(d);
            a = fs;
            b = t[DRIVE_W] ? '0 : t[SCALE_W-1:0];
        end else if (d < 0) begin
            t = fs_s + (DRIVE_W+1)'(d);
            a = t[DRIVE_W] ? '0 : t[SCALE_W-1:0];
            b = fs;
        end
        return {a, b};
    endfunction

    logic signed [DRIVE_W-1:0] dl;
    logic signed [DRIVE_W-1:0] dr;
    logic [2*SCALE_W-1:0]      pair_l;
    logic [2*SCALE_W-1:0]      pair_r;

    assign dl     = limit_drive(acc_left, cfg.drive_limit);
    assign dr     = limit_drive(acc_right, cfg.drive_limit);
    assign pair_l = map_pair(dl, cfg.full_scale);
    assign pair_r = map_pair(dr, cfg.full_scale);

    // output word register
    always_ff @(posedge aclk) begin
        if (load) begin
            drive_left  <= dl;
            drive_right <= dr;
            left_ch_a   <= pair_l[2*SCALE_W-1:SCALE_W];
            left_ch_b   <= pair_l[SCALE_W-1:0];
            right_ch_a  <= pair_r[2*SCALE_W-1:SCALE_W];
            right_ch_b  <= pair_r[SCALE_W-1:0];
        end
    end

endmodule

>>> test/tb_dual_incremental_pi_motor_drive.sv
`timescale 1ns / 100ps

module tb_dual_incremental_pi_motor_drive;
    import dipm_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int IDLE_LIMIT = 4000;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef logic [CFG_IDX_W+CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_left;
        logic [DRIVE_W-1:0] drive_right;
        logic [SCALE_W-1:0] left_ch_a;
        logic [SCALE_W-1:0] left_ch_b;
        logic [SCALE_W-1:0] right_ch_a;
        logic [SCALE_W-1:0] right_ch_b;
    } drive_word_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_encoder_left = '0;
    logic signed [SAMPLE_WIDTH-1:0] s_encoder_right = '0;
    logic signed [SAMPLE_WIDTH-1:0] s_target_left = '0;
    logic signed [SAMPLE_WIDTH-1:0] s_target_right = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [DRIVE_W-1:0]      m_drive_left;
    logic signed [DRIVE_W-1:0]      m_drive_right;
    logic [SCALE_W-1:0]             m_left_ch_a;
    logic [SCALE_W-1:0]             m_left_ch_b;
    logic [SCALE_W-1:0]             m_right_ch_a;
    logic [SCALE_W-1:0]             m_right_ch_b;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;

    // mirror of the drive state and registers
    longint             acc_l, acc_r, prev_bias_l, prev_bias_r;
    logic [GAIN_W-1:0]  kp, ki;
    logic [SCALE_W-1:0] fs, dlim, dz_pos, dz_neg;

    drive_word_t expected_drive_q[$];
    int unsigned ticks_sent = 0;
    int unsigned ticks_out = 0;
    int unsigned err_count = 0;
    int unsigned burst_left = 0;
    bit          tx_on = 1'b0;
    int unsigned rdy_left = 0;
    int unsigned idle_cycles = 0;

    dual_incremental_pi_motor_drive u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_encoder_left  (s_encoder_left),
        .s_encoder_right (s_encoder_right),
        .s_target_left   (s_target_left),
        .s_target_right  (s_target_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_left    (m_drive_left),
        .m_drive_right   (m_drive_right),
        .m_left_ch_a     (m_left_ch_a),
        .m_left_ch_b     (m_left_ch_b),
        .m_right_ch_a    (m_right_ch_a),
        .m_right_ch_b    (m_right_ch_b),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic longint sym_clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // incremental pi step: exact sum, truncate toward zero, clamp to full scale
    function automatic longint pi_step(longint acc, longint prev, longint bias);
        longint sum;
        sum = acc * 256 + longint'(kp) * (bias - prev) + longint'(ki) * bias;
        return sym_clip(sum / 256, longint'(fs));
    endfunction

    // complementary compare values, held at zero from below
    function automatic void pwm_map(input longint d, output logic [SCALE_W-1:0] a,
                                    output logic [SCALE_W-1:0] b);
        longint top, t;
        top = longint'(fs);
        if (d > 0) begin
            t = (top - d < 0) ? 0 : top - d;
            a = top[SCALE_W-1:0];
            b = t[SCALE_W-1:0];
        end else if (d < 0) begin
            t = (top + d < 0) ? 0 : top + d;
            a = t[SCALE_W-1:0];
            b = top[SCALE_W-1:0];
        end else begin
            a = '0;
            b = '0;
        end
    endfunction

    function automatic drive_word_t predict_drive(
        input logic signed [SAMPLE_WIDTH-1:0] el, er, tl, tr);
        drive_word_t w;
        longint tgt_l, bias_l, bias_r, dl, dr;
        tgt_l  = longint'(tl);
        bias_l = longint'(el) - tgt_l;
        bias_r = longint'(er) - longint'(tr);
        // left sign flip for small targets
        if (tgt_l != 0 && tgt_l <= FLIP_TARGET_MAX && tgt_l >= -FLIP_TARGET_MAX &&
            ((tgt_l > 0 && acc_l > FLIP_ACC_MIN) || (tgt_l < 0 && acc_l < -FLIP_ACC_MIN)))
            acc_l = -acc_l;
        acc_l = pi_step(acc_l, prev_bias_l, bias_l);
        prev_bias_l = bias_l;
        // left dead-zone jump
        if (acc_l < longint'(dz_pos) && acc_l > -longint'(dz_neg)) begin
            if (tgt_l > 0)
                acc_l = -longint'(dz_neg);
            else if (tgt_l < 0)
                acc_l = longint'(dz_pos);
        end
        acc_r = pi_step(acc_r, prev_bias_r, bias_r);
        prev_bias_r = bias_r;
        dl = sym_clip(acc_l, longint'(dlim));
        dr = sym_clip(acc_r, longint'(dlim));
        w.drive_left  = dl[DRIVE_W-1:0];
        w.drive_right = dr[DRIVE_W-1:0];
        pwm_map(dl, w.left_ch_a, w.left_ch_b);
        pwm_map(dr, w.right_ch_a, w.right_ch_b);
        return w;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // mirror registers, predict each accepted word, check each result
    always @(posedge aclk) begin : drive_scoreboard
        drive_word_t want;
        if (!aresetn) begin
            kp          = RST_GAIN_P;
            ki          = RST_GAIN_I;
            fs          = RST_FULL_SCALE;
            dlim        = RST_DRIVE_LIMIT;
            dz_pos      = RST_DEAD_POS;
            dz_neg      = RST_DEAD_NEG;
            acc_l       = 0;
            acc_r       = 0;
            prev_bias_l = 0;
            prev_bias_r = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN_P:      kp = cfg_data;
                    REG_GAIN_I:      ki = cfg_data;
                    REG_FULL_SCALE:  fs = cfg_data[SCALE_W-1:0];
                    REG_DRIVE_LIMIT: dlim = cfg_data[SCALE_W-1:0];
                    REG_DEAD_POS:    dz_pos = cfg_data[SCALE_W-1:0];
                    REG_DEAD_NEG:    dz_neg = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_drive_q.push_back(predict_drive(s_encoder_left, s_encoder_right,
                                                         s_target_left, s_target_right));
            if (m_valid && m_ready) begin
                ticks_out++;
                if (expected_drive_q.size() == 0) begin
                    $display("%0t unexpected result expected none actual drive %0d/%0d",
                             $time, m_drive_left, m_drive_right);
                    err_count++;
                end else begin
                    want = expected_drive_q.pop_front();
                    check_field("drive_left", $signed(want.drive_left), m_drive_left);
                    check_field("drive_right", $signed(want.drive_right), m_drive_right);
                    check_field("left_ch_a", want.left_ch_a, m_left_ch_a);
                    check_field("left_ch_b", want.left_ch_b, m_left_ch_b);
                    check_field("right_ch_a", want.right_ch_a, m_right_ch_a);
                    check_field("right_ch_b", want.right_ch_b, m_right_ch_b);
                end
            end
        end
    end

    // result side back-pressure: long open stretches, short stalls, choppy runs
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready  <= 1'b1;
                    rdy_left <= $urandom_range(40, 300);
                end
                1: begin
                    m_ready  <= 1'b0;
                    rdy_left <= $urandom_range(1, 12);
                end
                default: begin
                    m_ready  <= ~m_ready;
                    rdy_left <= $urandom_range(0, 3);
                end
            endcase
        end else begin
            rdy_left <= rdy_left - 1;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dual_incremental_pi_motor_drive regression: fail");
            $finish;
        end
    end

    // one tick word, sent in bursts with random gaps in between
    task automatic send_tick(input logic signed [SAMPLE_WIDTH-1:0] el, er, tl, tr);
        if (burst_left == 0) begin
            if (tx_on) begin
                s_valid <= 1'b0;
                tx_on = 1'b0;
            end
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 30);
        end
        s_valid         <= 1'b1;
        s_encoder_left  <= el;
        s_encoder_right <= er;
        s_target_left   <= tl;
        s_target_right  <= tr;
        tx_on = 1'b1;
        burst_left--;
        ticks_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain_results();
        if (tx_on) begin
            s_valid <= 1'b0;
            tx_on = 1'b0;
        end
        burst_left = 0;
        while (ticks_out < ticks_sent) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_word_t words[$]);
        drain_results();
        foreach (words[k]) begin
            cfg_valid              <= 1'b1;
            {cfg_index, cfg_data}  <= words[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // all six registers; spare upper bits of the narrow ones are randomized
    task automatic load_config(input cfg_t c);
        cfg_word_t words[$];
        words.push_back({REG_GAIN_P, c.gain_p});
        words.push_back({REG_GAIN_I, c.gain_i});
        words.push_back({REG_FULL_SCALE, 2'($urandom), c.full_scale});
        words.push_back({REG_DRIVE_LIMIT, 2'($urandom), c.drive_limit});
        words.push_back({REG_DEAD_POS, 2'($urandom), c.dead_pos});
        words.push_back({REG_DEAD_NEG, 2'($urandom), c.dead_neg});
        write_cfg(words);
    endtask

    function automatic cfg_t default_config();
        cfg_t c;
        c.gain_p      = RST_GAIN_P;
        c.gain_i      = RST_GAIN_I;
        c.full_scale  = RST_FULL_SCALE;
        c.drive_limit = RST_DRIVE_LIMIT;
        c.dead_pos    = RST_DEAD_POS;
        c.dead_neg    = RST_DEAD_NEG;
        return c;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom_range(0, 3072));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 5))
            0: return SCALE_W'(lo);
            1: return '1;
            default: return SCALE_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.gain_p      = pick_gain();
        c.gain_i      = pick_gain();
        c.full_scale  = pick_scale(1, 16383);
        c.drive_limit = pick_scale(0, 16383);
        c.dead_pos    = pick_scale(0, 3000);
        c.dead_neg    = pick_scale(0, 3000);
        return c;
    endfunction

    // mostly small biases around small or moderate targets, some raw words
    function automatic void pick_motor(output logic signed [SAMPLE_WIDTH-1:0] enc, tgt);
        int t, d;
        case ($urandom_range(0, 9))
            0, 1: begin
                t = int'($urandom);
                d = int'($urandom);
            end
            2, 3, 4, 5: begin
                t = int'($urandom_range(0, 8)) - 4;
                d = t + int'($urandom_range(0, 40)) - 20;
            end
            default: begin
                t = int'($urandom_range(0, 400)) - 200;
                d = t + int'($urandom_range(0, 200)) - 100;
            end
        endcase
        tgt = SAMPLE_WIDTH'(t);
        enc = SAMPLE_WIDTH'(d);
    endfunction

    task automatic test_field_extremes();
        send_tick(0, 0, 0, 0);
        send_tick(32767, -32768, -32768, 32767);
        send_tick(-32768, 32767, 32767, -32768);
        send_tick(32767, 32767, 32767, 32767);
    endtask

    // build up a large left drive, then small targets flip its sign
    task automatic test_left_flip();
        send_tick(300, 0, 0, 0);
        send_tick(2, 0, 2, 0);
        send_tick(-3, 0, -3, 0);
        send_tick(4, 0, 4, 0);
        send_tick(1, 0, 1, 0);
    endtask

    // zero gains with a tiny full scale: dead-zone jumps past the pwm top
    task automatic test_dead_zone_and_saturation();
        cfg_t c;
        c = default_config();
        c.gain_p     = '0;
        c.gain_i     = '0;
        c.full_scale = 14'd100;
        load_config(c);
        send_tick(5, 0, 5, 0);
        send_tick(-5, 0, -5, 0);
        send_tick(0, 0, 0, 0);
    endtask

    task automatic test_output_limit();
        cfg_t c;
        c = default_config();
        c.drive_limit = '0;
        load_config(c);
        send_tick(1000, -1000, 0, 0);
        c.drive_limit = 14'd50;
        load_config(c);
        send_tick(-1000, 1000, 0, 0);
        send_tick(1000, -1000, 0, 0);
    endtask

    // full scale of zero pins both accumulators, the dead zone still acts
    task automatic test_zero_full_scale();
        cfg_t c;
        c = default_config();
        c.full_scale = '0;
        load_config(c);
        send_tick(100, 100, 0, 0);
        send_tick(0, 0, 5, 0);
    endtask

    task automatic test_gain_extremes();
        cfg_t c;
        c = default_config();
        c.gain_p      = '1;
        c.gain_i      = '1;
        c.full_scale  = '1;
        c.drive_limit = '1;
        c.dead_pos    = '1;
        c.dead_neg    = '1;
        load_config(c);
        send_tick(32767, -32768, -32768, 32767);
        send_tick(-32768, 32767, 1, -3);
        c.gain_p   = '0;
        c.dead_pos = '0;
        c.dead_neg = '0;
        load_config(c);
        send_tick(-20, 20, 0, 0);
    endtask

    // writes to indexes without a register must leave the settings alone
    task automatic test_unknown_index();
        cfg_word_t words[$];
        load_config(default_config());
        words.push_back({REG_SPARE_A, 16'($urandom)});
        words.push_back({REG_SPARE_B, 16'($urandom)});
        write_cfg(words);
        send_tick(40, -40, 0, 0);
        send_tick(-7, 9, 0, 0);
    endtask

    task automatic test_random_phases();
        logic signed [SAMPLE_WIDTH-1:0] el, er, tl, tr;
        int unsigned pause_at;
        for (int p = 0; p < 12; p++) begin
            load_config((p == 0) ? default_config() : random_config());
            pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 149) : 0;
            for (int n = 0; n < 150; n++) begin
                if (n == pause_at)
                    drain_results();
                pick_motor(el, tl);
                pick_motor(er, tr);
                send_tick(el, er, tl, tr);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_left_flip();
        test_dead_zone_and_saturation();
        test_output_limit();
        test_zero_full_scale();
        test_gain_extremes();
        test_unknown_index();
        test_random_phases();
        drain_results();
        repeat (8) @(posedge aclk);
        if (expected_drive_q.size() != 0) begin
            $display("%0t results missing expected %0d actual 0", $time,
                     expected_drive_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("dual_incremental_pi_motor_drive regression: pass");
        else
            $display("dual_incremental_pi_motor_drive regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/dipm_pkg.sv
rtl/dipm_lane.sv
rtl/dipm_merge.sv
rtl/dual_incremental_pi_motor_drive.sv
test/tb_dual_incremental_pi_motor_drive.sv
